// File: hdl/pm_pkg.sv
// Shared constants and sizing helpers for the polynomial multiplier.
`default_nettype none

package pm_pkg;

	localparam int MAX_TERMS_DEF  = 16;
	localparam int COEF_WIDTH_DEF = 16;
	localparam int PROD_W         = 36;
	localparam int POWER_W        = 5;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic CMD_FIRST  = 1'b0;
	localparam logic CMD_SECOND = 1'b1;

	function automatic int idx_w(input int max_terms);
		return (max_terms > 1) ? $clog2(max_terms) : 1;
	endfunction

	function automatic int cnt_w(input int max_terms);
		return $clog2(max_terms + 1);
	endfunction

	// wr, sel, idx, coef, run, na, nb, zero, ovf
	function automatic int entry_w(input int max_terms, input int coef_width);
		return 2 + idx_w(max_terms) + coef_width + 1 + 2 * cnt_w(max_terms) + 2;
	endfunction

endpackage

`default_nettype wire

// File: hdl/pm_if.sv
// Handshake channel interfaces for operand items and product results.
`default_nettype none

interface pm_in_if #(
	parameter int COEF_WIDTH = pm_pkg::COEF_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic                         command;
	logic signed [COEF_WIDTH-1:0] coefficient;
	logic                         last_term;
	logic                         zero_operand;

	modport source (output valid, command, coefficient, last_term, zero_operand, input ready);
	modport sink (input valid, command, coefficient, last_term, zero_operand, output ready);
endinterface

interface pm_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [pm_pkg::PROD_W-1:0]   product_coefficient;
	logic [pm_pkg::POWER_W-1:0]         power;
	logic                               last_result;
	logic                               zero_product;
	logic                               overflow;

	modport source (output valid, product_coefficient, power, last_result, zero_product,
		overflow, input ready);
	modport sink (input valid, product_coefficient, power, last_result, zero_product,
		overflow, output ready);
endinterface

`default_nettype wire

// File: hdl/pm_front.sv
// Front end: takes operand items, tracks the pair and queues store writes and run requests.
`default_nettype none

module pm_front #(
	parameter int MAX_TERMS  = pm_pkg::MAX_TERMS_DEF,
	parameter int COEF_WIDTH = pm_pkg::COEF_WIDTH_DEF
) (
	input  wire logic                                                 clk,
	input  wire logic                                                 arst_n,
	pm_in_if.sink                                                     items,
	output logic                                                      push_valid,
	input  wire logic                                                 push_ready,
	output logic [pm_pkg::entry_w(MAX_TERMS, COEF_WIDTH)-1:0]         push_data
);

	localparam int IDX_W = pm_pkg::idx_w(MAX_TERMS);
	localparam int CNT_W = pm_pkg::cnt_w(MAX_TERMS);

	typedef struct packed {
		logic                  wr;
		logic                  sel;
		logic [IDX_W-1:0]      idx;
		logic [COEF_WIDTH-1:0] coef;
		logic                  run;
		logic [CNT_W-1:0]      na;
		logic [CNT_W-1:0]      nb;
		logic                  zero;
		logic                  ovf;
	} entry_t;

	logic [CNT_W-1:0] a_cnt_q, b_cnt_q, a_cnt_d, b_cnt_d, cur_cnt;
	logic             a_done_q, b_done_q, a_done_d, b_done_d;
	logic             a_zero_q, b_zero_q, a_zero_d, b_zero_d;
	logic             drop_q, drop_d;
	logic             accept, second, cur_done;
	entry_t           ent;

	assign items.ready = push_ready;
	assign push_data   = ent;

	always_comb begin
		a_cnt_d  = a_cnt_q;
		b_cnt_d  = b_cnt_q;
		a_done_d = a_done_q;
		b_done_d = b_done_q;
		a_zero_d = a_zero_q;
		b_zero_d = b_zero_q;
		drop_d   = drop_q;
		accept   = items.valid && items.ready;
		second   = (items.command == pm_pkg::CMD_SECOND);
		cur_cnt  = second ? b_cnt_q : a_cnt_q;
		cur_done = second ? b_done_q : a_done_q;
		ent      = '0;
		ent.sel  = items.command;
		ent.coef = items.coefficient;

		// items for a closed operand are taken and dropped silently
		if (accept && !cur_done) begin
			if (items.zero_operand) begin
				if (second) begin
					b_zero_d = 1'b1;
					b_done_d = 1'b1;
					b_cnt_d  = '0;
				end else begin
					a_zero_d = 1'b1;
					a_done_d = 1'b1;
					a_cnt_d  = '0;
				end
			end else begin
				if (cur_cnt < CNT_W'(MAX_TERMS)) begin
					ent.wr  = 1'b1;
					ent.idx = cur_cnt[IDX_W-1:0];
					if (second) begin
						b_cnt_d = cur_cnt + CNT_W'(1);
					end else begin
						a_cnt_d = cur_cnt + CNT_W'(1);
					end
				end else begin
					drop_d = 1'b1;
				end
				if (items.last_term) begin
					if (second) begin
						b_done_d = 1'b1;
					end else begin
						a_done_d = 1'b1;
					end
				end
			end
		end

		if (a_done_d && b_done_d) begin
			ent.run  = 1'b1;
			ent.na   = a_cnt_d;
			ent.nb   = b_cnt_d;
			ent.zero = a_zero_d || b_zero_d || (a_cnt_d == '0) || (b_cnt_d == '0);
			ent.ovf  = drop_d;
			a_cnt_d  = '0;
			b_cnt_d  = '0;
			a_done_d = 1'b0;
			b_done_d = 1'b0;
			a_zero_d = 1'b0;
			b_zero_d = 1'b0;
			drop_d   = 1'b0;
		end

		push_valid = accept && (ent.wr || ent.run);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_cnt_q  <= '0;
			b_cnt_q  <= '0;
			a_done_q <= 1'b0;
			b_done_q <= 1'b0;
			a_zero_q <= 1'b0;
			b_zero_q <= 1'b0;
			drop_q   <= 1'b0;
		end else begin
			a_cnt_q  <= a_cnt_d;
			b_cnt_q  <= b_cnt_d;
			a_done_q <= a_done_d;
			b_done_q <= b_done_d;
			a_zero_q <= a_zero_d;
			b_zero_q <= b_zero_d;
			drop_q   <= drop_d;
		end
	end

endmodule

`default_nettype wire

// File: hdl/pm_queue.sv
// Small FIFO between the front end and the convolution engine.
`default_nettype none

module pm_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = pm_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [WIDTH-1:0] in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [WIDTH-1:0]      out_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [FW-1:0]    fill_q;
	logic             push, pop;

	assign in_ready  = (fill_q != FW'(DEPTH));
	assign out_valid = (fill_q != '0);
	assign out_data  = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

`default_nettype wire

// File: hdl/pm_back.sv
// Back end: operand stores and a pipelined multiply-accumulate that walks the convolution.
`default_nettype none

module pm_back #(
	parameter int MAX_TERMS  = pm_pkg::MAX_TERMS_DEF,
	parameter int COEF_WIDTH = pm_pkg::COEF_WIDTH_DEF
) (
	input  wire logic                                                 clk,
	input  wire logic                                                 arst_n,
	input  wire logic                                                 q_valid,
	output logic                                                      q_ready,
	input  wire logic [pm_pkg::entry_w(MAX_TERMS, COEF_WIDTH)-1:0]    q_data,
	pm_out_if.source                                                  results
);

	localparam int IDX_W = pm_pkg::idx_w(MAX_TERMS);
	localparam int CNT_W = pm_pkg::cnt_w(MAX_TERMS);
	localparam int KW    = $clog2(2 * MAX_TERMS);
	localparam int PW    = pm_pkg::PROD_W;

	typedef struct packed {
		logic                  wr;
		logic                  sel;
		logic [IDX_W-1:0]      idx;
		logic [COEF_WIDTH-1:0] coef;
		logic                  run;
		logic [CNT_W-1:0]      na;
		logic [CNT_W-1:0]      nb;
		logic                  zero;
		logic                  ovf;
	} entry_t;

	typedef struct packed {
		logic          first;
		logic          k_end;
		logic          p_end;
		logic          zero;
		logic          ovf;
		logic [KW-1:0] k;
	} tag_t;

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	logic signed [COEF_WIDTH-1:0] store_a [MAX_TERMS];
	logic signed [COEF_WIDTH-1:0] store_b [MAX_TERMS];

	state_t           state_q;
	logic [KW-1:0]    k_q, kmax, k_nx;
	logic [IDX_W-1:0] i_q, iend, istart_nx, b_idx;
	logic [CNT_W-1:0] na_q, nb_q;
	logic             run_zero_q, run_ovf_q, first_q;
	logic             issue, adv, emit, pop;
	entry_t           ent;
	tag_t             tag_cur, tag_s1, tag_s2;
	logic             v_s1, v_s2;

	logic signed [COEF_WIDTH-1:0]   rd_a_s1, rd_b_s1;
	logic signed [2*COEF_WIDTH-1:0] prod_s2;
	logic signed [63:0]             prod_64;
	logic signed [PW-1:0]           acc_q, acc_sum;

	logic                           out_valid_q, last_q, zero_q, ovf_q;
	logic signed [PW-1:0]           coef_q;
	logic [pm_pkg::POWER_W-1:0]     power_q;

	assign ent     = entry_t'(q_data);
	assign q_ready = (state_q == ST_IDLE);
	assign pop     = q_valid && q_ready;

	// term range for output power k: i from max(0, k-nb+1) to min(k, na-1)
	assign kmax      = KW'(na_q) + KW'(nb_q) - KW'(2);
	assign k_nx      = k_q + KW'(1);
	assign iend      = (k_q < KW'(na_q)) ? k_q[IDX_W-1:0] : IDX_W'(na_q - CNT_W'(1));
	assign istart_nx = (k_nx >= KW'(nb_q)) ? IDX_W'(k_nx - KW'(nb_q) + KW'(1)) : '0;
	assign b_idx     = IDX_W'(k_q - KW'(i_q));

	// whole MAC pipeline holds while a finished coefficient cannot leave
	assign adv   = !(v_s2 && tag_s2.k_end && out_valid_q && !results.ready);
	assign issue = (state_q == ST_RUN) && adv;
	assign emit  = v_s2 && tag_s2.k_end && adv;

	always_comb begin
		tag_cur.first = first_q;
		tag_cur.k_end = (i_q == iend);
		tag_cur.p_end = (k_q == kmax);
		tag_cur.zero  = run_zero_q;
		tag_cur.ovf   = run_ovf_q;
		tag_cur.k     = k_q;
	end

	assign prod_64 = 64'(prod_s2);
	assign acc_sum = (tag_s2.first ? '0 : acc_q) + prod_64[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			i_q         <= '0;
			na_q        <= '0;
			nb_q        <= '0;
			run_zero_q  <= 1'b0;
			run_ovf_q   <= 1'b0;
			first_q     <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop && ent.run) begin
						state_q    <= ST_RUN;
						k_q        <= '0;
						i_q        <= '0;
						first_q    <= 1'b1;
						run_zero_q <= ent.zero;
						run_ovf_q  <= ent.ovf;
						// a zero product goes through as a single forced term
						na_q       <= ent.zero ? CNT_W'(1) : ent.na;
						nb_q       <= ent.zero ? CNT_W'(1) : ent.nb;
					end
				end
				ST_RUN: begin
					if (adv) begin
						if (i_q == iend) begin
							first_q <= 1'b1;
							if (k_q == kmax) begin
								state_q <= ST_IDLE;
							end else begin
								k_q <= k_nx;
								i_q <= istart_nx;
							end
						end else begin
							first_q <= 1'b0;
							i_q     <= i_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (adv) begin
				v_s1 <= issue;
				v_s2 <= v_s1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && ent.wr) begin
			if (ent.sel == pm_pkg::CMD_SECOND) begin
				store_b[ent.idx] <= ent.coef;
			end else begin
				store_a[ent.idx] <= ent.coef;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_a_s1 <= store_a[i_q];
			rd_b_s1 <= store_b[b_idx];
			tag_s1  <= tag_cur;
			prod_s2 <= rd_a_s1 * rd_b_s1;
			tag_s2  <= tag_s1;
			if (v_s2) begin
				acc_q <= acc_sum;
			end
		end
		if (emit) begin
			coef_q  <= tag_s2.zero ? '0 : acc_sum;
			power_q <= pm_pkg::POWER_W'(tag_s2.k);
			last_q  <= tag_s2.p_end;
			zero_q  <= tag_s2.zero;
			ovf_q   <= tag_s2.ovf;
		end
	end

	assign results.valid               = out_valid_q;
	assign results.product_coefficient = coef_q;
	assign results.power               = power_q;
	assign results.last_result         = last_q;
	assign results.zero_product        = zero_q;
	assign results.overflow            = ovf_q;

endmodule

`default_nettype wire

// File: hdl/polynomial_multiplier.sv
// Polynomial multiplier: one coefficient transfer per cycle in while the queue has room; product terms through one MAC.
// The run request that closes a pair passes the queue, the sequencer, the MAC stages and the output register.
// Throughput: one multiply-accumulate per cycle while the output is not stalled; a product of
// na by nb terms walks all na*nb term pairs through the single shared multiplier; a zero product is one forced term.
// Items stall once the two-entry queue fills while a product is running.
// Reset: arst_n clears the pair tracking, queue, sequencer and output valid; stores keep data.
`default_nettype none

module polynomial_multiplier #(
	parameter int MAX_TERMS  = pm_pkg::MAX_TERMS_DEF,
	parameter int COEF_WIDTH = pm_pkg::COEF_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pm_in_if.sink     items,
	pm_out_if.source  results
);

	localparam int EW = pm_pkg::entry_w(MAX_TERMS, COEF_WIDTH);

	logic          push_valid, push_ready, q_valid, q_ready;
	logic [EW-1:0] push_data, q_data;

	pm_front #(
		.MAX_TERMS (MAX_TERMS),
		.COEF_WIDTH(COEF_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	pm_queue #(
		.WIDTH(EW),
		.DEPTH(pm_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (push_valid),
		.in_ready (push_ready),
		.in_data  (push_data),
		.out_valid(q_valid),
		.out_ready(q_ready),
		.out_data (q_data)
	);

	pm_back #(
		.MAX_TERMS (MAX_TERMS),
		.COEF_WIDTH(COEF_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_data (q_data),
		.results(results)
	);

endmodule

`default_nettype wire

// File: hdl/pm_checker.sv
// Port-level checks on the result channel, bound to the top level.
`default_nettype none

module pm_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               out_valid,
	input wire logic                               out_ready,
	input wire logic signed [pm_pkg::PROD_W-1:0]   out_coef,
	input wire logic [pm_pkg::POWER_W-1:0]         out_power,
	input wire logic                               out_last,
	input wire logic                               out_zero
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_coef) && $stable(out_power)
			&& $stable(out_last))
		else $error("result changed while stalled");

	a_zero_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_zero |-> out_last && (out_power == '0) && (out_coef == '0))
		else $error("zero product not a single power-0 term");

	a_power_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=>
			!out_valid || (out_power == $past(out_power) + pm_pkg::POWER_W'(1)))
		else $error("product powers not consecutive");

	a_power_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !out_valid || (out_power == '0))
		else $error("new product does not start at power 0");

endmodule

bind polynomial_multiplier pm_checker u_pm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_coef (results.product_coefficient),
	.out_power(results.power),
	.out_last (results.last_result),
	.out_zero (results.zero_product)
);

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the polynomial multiplier: directed and random operand pairs.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TERMS        = pm_pkg::MAX_TERMS_DEF;
	localparam int CW           = pm_pkg::COEF_WIDTH_DEF;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int SETTLE_CYCLES = 30;
	localparam int RANDOM_ITEMS = 150;
	localparam int CALM_ITEMS   = 50;
	localparam int HOLD_CYCLES  = 300;

	typedef logic signed [CW-1:0] coef_t;

	typedef struct packed {
		logic signed [pm_pkg::PROD_W-1:0] coefficient;
		logic [pm_pkg::POWER_W-1:0]       power;
		logic                             last_result;
		logic                             zero_product;
		logic                             overflow;
	} product_term_t;

	logic clk = 1'b0;
	logic arst_n;

	pm_in_if #(.COEF_WIDTH(CW)) items_if ();
	pm_out_if results_if ();

	polynomial_multiplier #(
		.MAX_TERMS (TERMS),
		.COEF_WIDTH(CW)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_if),
		.results(results_if)
	);

	// shadow of the operand stores and pair tracking
	coef_t         operand_terms [2][TERMS];
	int            operand_len [2];
	logic          operand_closed [2];
	logic          operand_zero [2];
	logic          terms_dropped;
	product_term_t product_queue [$];

	int   error_count = 0;
	int   cycle_count = 0;
	logic idle_on = 1'b1;
	int   hold_left = 0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	function automatic void clear_pair_state();
		for (int s = 0; s < 2; s++) begin
			operand_len[s]    = 0;
			operand_closed[s] = 1'b0;
			operand_zero[s]   = 1'b0;
		end
		terms_dropped = 1'b0;
	endfunction

	// Folds one accepted item into the shadow state; queues the product once both close.
	function automatic void take_operand_item(input logic cmd, input coef_t coef,
			input logic last, input logic zop);
		int            s;
		int            total;
		longint        acc;
		product_term_t term;
		s = (cmd == pm_pkg::CMD_SECOND) ? 1 : 0;
		if (!operand_closed[s]) begin
			if (zop) begin
				operand_zero[s]   = 1'b1;
				operand_closed[s] = 1'b1;
				operand_len[s]    = 0;
			end else begin
				if (operand_len[s] < TERMS) begin
					operand_terms[s][operand_len[s]] = coef;
					operand_len[s]++;
				end else begin
					terms_dropped = 1'b1;
				end
				if (last)
					operand_closed[s] = 1'b1;
			end
		end
		if (!(operand_closed[0] && operand_closed[1]))
			return;
		if (operand_zero[0] || operand_zero[1] || operand_len[0] == 0 || operand_len[1] == 0) begin
			term.coefficient  = '0;
			term.power        = '0;
			term.last_result  = 1'b1;
			term.zero_product = 1'b1;
			term.overflow     = terms_dropped;
			product_queue.push_back(term);
		end else begin
			total = operand_len[0] + operand_len[1] - 1;
			for (int k = 0; k < total; k++) begin
				acc = 0;
				for (int i = 0; i < operand_len[0]; i++)
					if (k - i >= 0 && k - i < operand_len[1])
						acc += longint'(operand_terms[0][i]) * longint'(operand_terms[1][k - i]);
				term.coefficient  = acc[pm_pkg::PROD_W-1:0];
				term.power        = k[pm_pkg::POWER_W-1:0];
				term.last_result  = (k + 1 == total);
				term.zero_product = 1'b0;
				term.overflow     = terms_dropped;
				product_queue.push_back(term);
			end
		end
		clear_pair_state();
	endfunction

	function automatic coef_t random_coef();
		case ($urandom_range(0, 9))
			0: return coef_t'(-32768);
			1: return coef_t'(32767);
			2: return coef_t'(0);
			3: return coef_t'(-1);
			default: return coef_t'($urandom);
		endcase
	endfunction

	// Called on a rising edge; returns on the edge of the transfer.
	task automatic send_item(input logic cmd, input coef_t coef, input logic last,
			input logic zop);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 12);
		if (gap > 0) begin
			items_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_if.valid        <= 1'b1;
		items_if.command      <= cmd;
		items_if.coefficient  <= coef;
		items_if.last_term    <= last;
		items_if.zero_operand <= zop;
		do @(posedge clk); while (items_if.ready !== 1'b1);
		take_operand_item(cmd, coef, last, zop);
	endtask

	task automatic wait_for_products();
		items_if.valid <= 1'b0;
		while (product_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result sink: random stalls plus an optional long hold-off
	initial begin
		int stall_left;
		stall_left = 0;
		results_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				results_if.ready <= 1'b0;
			end else if (!idle_on) begin
				results_if.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				results_if.ready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		product_term_t want;
		if (arst_n === 1'b1 && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
			if (product_queue.size() == 0) begin
				$error("unexpected transfer: power %0d coefficient %0d",
					results_if.power, results_if.product_coefficient);
				error_count++;
			end else begin
				want = product_queue.pop_front();
				if (results_if.product_coefficient !== want.coefficient) begin
					$error("product_coefficient: expected %0d, got %0d",
						want.coefficient, results_if.product_coefficient);
					error_count++;
				end
				if (results_if.power !== want.power) begin
					$error("power: expected %0d, got %0d", want.power, results_if.power);
					error_count++;
				end
				if (results_if.last_result !== want.last_result) begin
					$error("last_result: expected %0b, got %0b",
						want.last_result, results_if.last_result);
					error_count++;
				end
				if (results_if.zero_product !== want.zero_product) begin
					$error("zero_product: expected %0b, got %0b",
						want.zero_product, results_if.zero_product);
					error_count++;
				end
				if (results_if.overflow !== want.overflow) begin
					$error("overflow: expected %0b, got %0b", want.overflow, results_if.overflow);
					error_count++;
				end
			end
		end
	end

	task automatic test_extremes();
		send_item(pm_pkg::CMD_FIRST, coef_t'(-32768), 1'b0, 1'b0);
		send_item(pm_pkg::CMD_FIRST, coef_t'(32767), 1'b1, 1'b0);
		send_item(pm_pkg::CMD_SECOND, coef_t'(-32768), 1'b1, 1'b0);
		// second operand first this time
		send_item(pm_pkg::CMD_SECOND, coef_t'(32767), 1'b0, 1'b0);
		send_item(pm_pkg::CMD_SECOND, coef_t'(-1), 1'b1, 1'b0);
		send_item(pm_pkg::CMD_FIRST, coef_t'(32767), 1'b1, 1'b0);
	endtask

	task automatic test_zero_operand();
		send_item(pm_pkg::CMD_FIRST, coef_t'(1234), 1'b1, 1'b1);
		send_item(pm_pkg::CMD_SECOND, coef_t'(5), 1'b0, 1'b0);
		send_item(pm_pkg::CMD_SECOND, coef_t'(-3), 1'b1, 1'b0);
		// zero after coefficients discards them
		send_item(pm_pkg::CMD_FIRST, coef_t'(7), 1'b0, 1'b0);
		send_item(pm_pkg::CMD_FIRST, coef_t'(-4321), 1'b0, 1'b1);
		send_item(pm_pkg::CMD_SECOND, coef_t'(9), 1'b1, 1'b0);
		send_item(pm_pkg::CMD_FIRST, coef_t'(1), 1'b1, 1'b0);
		send_item(pm_pkg::CMD_SECOND, coef_t'(-1), 1'b0, 1'b1);
	endtask

	task automatic test_ignored_items();
		send_item(pm_pkg::CMD_FIRST, coef_t'(3), 1'b1, 1'b0);
		send_item(pm_pkg::CMD_FIRST, coef_t'(99), 1'b1, 1'b0);
		send_item(pm_pkg::CMD_SECOND, coef_t'(4), 1'b1, 1'b0);
	endtask

	task automatic test_zero_coefficients();
		send_item(pm_pkg::CMD_FIRST, coef_t'(0), 1'b0, 1'b0);
		send_item(pm_pkg::CMD_FIRST, coef_t'(0), 1'b1, 1'b0);
		send_item(pm_pkg::CMD_SECOND, coef_t'(0), 1'b1, 1'b0);
	endtask

	task automatic test_dropped_terms();
		for (int i = 0; i < TERMS + 2; i++)
			send_item(pm_pkg::CMD_FIRST, random_coef(), i == TERMS + 1, 1'b0);
		send_item(pm_pkg::CMD_SECOND, random_coef(), 1'b0, 1'b0);
		send_item(pm_pkg::CMD_SECOND, random_coef(), 1'b1, 1'b0);
		send_item(pm_pkg::CMD_FIRST, random_coef(), 1'b1, 1'b0);
		for (int i = 0; i < TERMS + 1; i++)
			send_item(pm_pkg::CMD_SECOND, random_coef(), i == TERMS, 1'b0);
		// longest product, no drops
		for (int i = 0; i < 2 * TERMS; i++)
			send_item((i % 2) ? pm_pkg::CMD_SECOND : pm_pkg::CMD_FIRST, random_coef(),
				i >= 2 * TERMS - 2, 1'b0);
	endtask

	task automatic test_backpressure();
		idle_on   = 1'b0;
		hold_left = HOLD_CYCLES;
		for (int p = 0; p < 8; p++) begin
			for (int i = 0; i < 3; i++)
				send_item(pm_pkg::CMD_FIRST, random_coef(), i == 2, 1'b0);
			for (int i = 0; i < 3; i++)
				send_item(pm_pkg::CMD_SECOND, random_coef(), i == 2, 1'b0);
		end
	endtask

	task automatic test_random_pairs(input int item_budget, input logic calm);
		int   sent;
		int   goal [2];
		int   pos [2];
		logic closed [2];
		int   s;
		int   r;
		logic zop;
		sent = 0;
		while (sent < item_budget) begin
			idle_on = calm ? 1'b0 : ($urandom_range(0, 4) != 0);
			for (s = 0; s < 2; s++) begin
				r = $urandom_range(0, 19);
				if (r < 14)
					goal[s] = $urandom_range(1, 4);
				else if (r < 18)
					goal[s] = $urandom_range(5, TERMS);
				else
					goal[s] = $urandom_range(TERMS + 1, TERMS + 4);
				pos[s]    = 0;
				closed[s] = 1'b0;
			end
			while (!(closed[0] && closed[1])) begin
				if ((closed[0] ^ closed[1]) && $urandom_range(0, 9) == 0) begin
					// stray transfer to the closed side
					s = closed[0] ? 0 : 1;
					send_item(s ? pm_pkg::CMD_SECOND : pm_pkg::CMD_FIRST, random_coef(),
						logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
				end else begin
					s   = closed[0] ? 1 : (closed[1] ? 0 : $urandom_range(0, 1));
					zop = ($urandom_range(0, 24) == 0);
					send_item(s ? pm_pkg::CMD_SECOND : pm_pkg::CMD_FIRST, random_coef(),
						zop ? logic'($urandom_range(0, 1)) : (pos[s] + 1 == goal[s]), zop);
					pos[s]++;
					if (zop || pos[s] == goal[s])
						closed[s] = 1'b1;
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n                <= 1'b0;
		items_if.valid        <= 1'b0;
		items_if.command      <= pm_pkg::CMD_FIRST;
		items_if.coefficient  <= '0;
		items_if.last_term    <= 1'b0;
		items_if.zero_operand <= 1'b0;
		clear_pair_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_zero_operand();
		test_ignored_items();
		test_zero_coefficients();
		wait_for_products();
		test_dropped_terms();
		wait_for_products();
		test_backpressure();
		wait_for_products();
		test_random_pairs(RANDOM_ITEMS, 1'b0);
		test_random_pairs(CALM_ITEMS, 1'b1);
		wait_for_products();

		if (error_count == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire
